@@ rtl/lrupf_pkg.sv @@
package lrupf_pkg;

    localparam int FRAMES  = 16;
    localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PAGE_W  = 16;
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 5;
    localparam int OUT_W   = 2;

    localparam logic [OUT_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUT_W-1:0] OUT_FILL  = 2'd1;
    localparam logic [OUT_W-1:0] OUT_EVICT = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [STAMP_W-1:0] stamp_t;

    typedef struct packed {
        logic   en;
        idx_t   idx;
        page_t  page;
        stamp_t stamp;
    } tbl_wr_t;

    typedef struct packed {
        logic   valid;
        page_t  page;
        stamp_t stamp;
    } tbl_rd_t;

    // last frame index taking part in mapping
    function automatic idx_t last_frame(input logic [CFG_W-1:0] cfg);
        idx_t r;
        if (cfg == '0) begin
            r = '0;
        end else if (int'(cfg) > FRAMES) begin
            r = IDX_W'(FRAMES - 1);
        end else begin
            r = IDX_W'(cfg - CFG_W'(1));
        end
        return r;
    endfunction

endpackage

@@ rtl/lrupf_table.sv @@
module lrupf_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  lrupf_pkg::tbl_wr_t  wr,
    input  lrupf_pkg::idx_t     rd_idx,
    output lrupf_pkg::tbl_rd_t  rd
);

    lrupf_pkg::page_t               page_reg  [lrupf_pkg::FRAMES];
    lrupf_pkg::stamp_t              stamp_reg [lrupf_pkg::FRAMES];
    logic [lrupf_pkg::FRAMES-1:0]   valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            page_reg[wr.idx]  <= wr.page;
            stamp_reg[wr.idx] <= wr.stamp;
        end
    end

    assign rd.valid = valid_reg[rd_idx];
    assign rd.page  = page_reg[rd_idx];
    assign rd.stamp = stamp_reg[rd_idx];

endmodule

@@ rtl/lru_page_frame_replacement_top.sv @@
// LRU page-frame table. Each request on s_ (s_page_number) is one virtual page
// access; its result leaves on m_ as outcome (hit, free-frame fill, eviction),
// frame index, evicted page and the access stamp taken from a saturating
// 32-bit access counter.
// cfg_data sets the number of frames in use (0 acts as 1, above 16 as 16);
// cfg_ready is always high, and a write belongs between requests.
// A request steps the sequencer through a match/free scan from frame 0 that
// stops at the first free or matching frame, then, on an eviction only, an
// oldest-stamp scan over all frames in use, then a finish step that loads the
// output register and updates the table. One frame-table read port and one
// stamp comparator serve both scans, so no new request is taken before the
// previous one has left the finish step.
// s_ready is high only while the sequencer is idle.
// The result sits in an output register: a new request is taken while it
// waits, but a stalled m_ready holds the next result and the table update.
// Reset (aresetn, synchronous, active low) marks all frames free, clears the
// access counter and sets the frame count to 16.
module lru_page_frame_replacement_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lrupf_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lrupf_pkg::PAGE_W-1:0]         s_page_number,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lrupf_pkg::OUT_W-1:0]          m_outcome,
    output logic [lrupf_pkg::IDX_W-1:0]          m_frame_index,
    output logic [lrupf_pkg::PAGE_W-1:0]         m_evicted_page,
    output logic [lrupf_pkg::STAMP_W-1:0]        m_access_stamp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_OLDEST,
        ST_FINISH
    } state_t;

    state_t                          state_reg;
    logic [lrupf_pkg::CFG_W-1:0]     cfg_reg;
    lrupf_pkg::stamp_t               time_reg;
    lrupf_pkg::idx_t                 idx_reg;
    lrupf_pkg::idx_t                 last_reg;
    lrupf_pkg::idx_t                 victim_reg;
    lrupf_pkg::page_t                page_reg;
    lrupf_pkg::page_t                evict_reg;
    lrupf_pkg::stamp_t               stamp_reg;
    lrupf_pkg::stamp_t               min_reg;
    logic [lrupf_pkg::OUT_W-1:0]     outcome_reg;

    logic                            m_valid_reg;
    logic [lrupf_pkg::OUT_W-1:0]     m_outcome_reg;
    lrupf_pkg::idx_t                 m_frame_index_reg;
    lrupf_pkg::page_t                m_evicted_page_reg;
    lrupf_pkg::stamp_t               m_access_stamp_reg;

    lrupf_pkg::tbl_wr_t              tbl_wr;
    lrupf_pkg::tbl_rd_t              tbl_rd;
    logic                            out_free;
    logic                            older;

    lrupf_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .rd_idx  (idx_reg),
        .rd      (tbl_rd)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign older     = (idx_reg == '0) || (tbl_rd.stamp < min_reg);

    always_comb begin
        tbl_wr.en    = (state_reg == ST_FINISH) && out_free;
        tbl_wr.idx   = victim_reg;
        tbl_wr.page  = page_reg;
        tbl_wr.stamp = stamp_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= lrupf_pkg::CFG_RESET;
            time_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        page_reg  <= s_page_number;
                        stamp_reg <= time_reg;
                        evict_reg <= '0;
                        idx_reg   <= '0;
                        last_reg  <= lrupf_pkg::last_frame(cfg_reg);
                        if (time_reg != '1) begin
                            time_reg <= time_reg + lrupf_pkg::STAMP_W'(1);
                        end
                        state_reg <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    priority if (!tbl_rd.valid) begin
                        outcome_reg <= lrupf_pkg::OUT_FILL;
                        victim_reg  <= idx_reg;
                        state_reg   <= ST_FINISH;
                    end else if (tbl_rd.page == page_reg) begin
                        outcome_reg <= lrupf_pkg::OUT_HIT;
                        victim_reg  <= idx_reg;
                        state_reg   <= ST_FINISH;
                    end else if (idx_reg == last_reg) begin
                        outcome_reg <= lrupf_pkg::OUT_EVICT;
                        idx_reg     <= '0;
                        state_reg   <= ST_OLDEST;
                    end else begin
                        idx_reg <= idx_reg + lrupf_pkg::IDX_W'(1);
                    end
                end
                ST_OLDEST: begin
                    if (older) begin
                        min_reg    <= tbl_rd.stamp;
                        victim_reg <= idx_reg;
                        evict_reg  <= tbl_rd.page;
                    end
                    if (idx_reg == last_reg) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        idx_reg <= idx_reg + lrupf_pkg::IDX_W'(1);
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_outcome_reg      <= outcome_reg;
                        m_frame_index_reg  <= victim_reg;
                        m_evicted_page_reg <= evict_reg;
                        m_access_stamp_reg <= stamp_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_outcome      = m_outcome_reg;
    assign m_frame_index  = m_frame_index_reg;
    assign m_evicted_page = m_evicted_page_reg;
    assign m_access_stamp = m_access_stamp_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one in flight");

    a_time_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (time_reg >= $past(time_reg)))
        else $error("access counter moved backward");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside finish step");

    a_evicted_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_outcome != lrupf_pkg::OUT_EVICT)) |-> (m_evicted_page == '0))
        else $error("evicted page set without eviction");

    a_frame_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |-> (victim_reg <= last_reg))
        else $error("victim frame beyond frames in use");

endmodule
